FILE: rtl/core/gpci_pkg.sv
// ----------------------------------------------------------------------------
// gpci_pkg
// Shared types and constants for the grid point to cell index core.
// ----------------------------------------------------------------------------
package gpci_pkg;

   localparam int unsigned CoordW  = 32;
   localparam int unsigned CellW   = 16;
   localparam int unsigned SizeW   = 31;
   localparam int unsigned AxisW   = 2;
   localparam int unsigned SlotW   = 10;
   localparam int unsigned CsrIdxW = 3;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [AxisW-1:0] AXIS_X = 2'd0;
   localparam logic [AxisW-1:0] AXIS_Y = 2'd1;
   localparam logic [AxisW-1:0] AXIS_Z = 2'd2;

   localparam logic [CsrIdxW-1:0] CSR_MODE     = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_ANCHOR_X = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_ANCHOR_Y = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_ANCHOR_Z = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_SIZE_X   = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_SIZE_Y   = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_SIZE_Z   = 3'd6;

   typedef struct packed {
      logic                     operation;
      logic [AxisW-1:0]         axis;
      logic [SlotW-1:0]         face_index;
      logic signed [CoordW-1:0] face_value;
      logic                     last_face;
      logic signed [CoordW-1:0] point_x;
      logic signed [CoordW-1:0] point_y;
      logic signed [CoordW-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [CellW-1:0]  cell_x;
      logic signed [CellW-1:0]  cell_y;
      logic signed [CellW-1:0]  cell_z;
      logic signed [CoordW-1:0] pos_x;
      logic signed [CoordW-1:0] pos_y;
      logic signed [CoordW-1:0] pos_z;
   } rsp_type;

   // divider control: start, operands, and completion
   typedef struct packed {
      logic        start;
      logic        neg;       // numerator sign
      logic [63:0] mag;       // |numerator|, below 2^64
      logic [31:0] den;       // positive divisor
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quo;       // floor quotient magnitude info, see divider
      logic        rem_nz;
   } div_sts_type;

endpackage

FILE: rtl/core/gpci_if.sv
// ----------------------------------------------------------------------------
// gpci_req_if / gpci_rsp_if
// Valid/ready channels for the grid point to cell index core.
// ----------------------------------------------------------------------------
interface gpci_req_if;
   import gpci_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface gpci_rsp_if;
   import gpci_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/gpci_divider.sv
// ----------------------------------------------------------------------------
// gpci_divider
// Radix-2 restoring divider, unsigned 64 by 32, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gpci_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  gpci_pkg::div_cmd_type cmd,
   output gpci_pkg::div_sts_type sts
);
   import gpci_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;
   logic [33:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[31:0], quo_ff[63]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      if (cmd.start) begin
         quo_in  = cmd.mag;
         rem_in  = '0;
         den_in  = cmd.den;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done   = done_ff;
   assign sts.quo    = quo_ff;
   assign sts.rem_nz = (rem_ff != '0);

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset)
                    busy_ff && !cmd.start |=> cnt_ff == $past(cnt_ff) - 7'd1)
      else $error("divider count skipped");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> cnt_ff != 7'd0)
      else $error("divider busy with zero count");

endmodule

FILE: rtl/core/grid_point_to_cell_index_core.sv
// ----------------------------------------------------------------------------
// grid_point_to_cell_index_core
// Maps a Q16.16 point to per-axis cell and continuous indices, uniform or
// stretched (face table binary search).
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  req     | in  | valid / ready    | operation, axis, face_index, ... point_z
//  rsp     | out | valid / ready    | cell_x/y/z, pos_x/y/z
//  csr     | in  | csr_write_enable | csr_index, csr_write_data (32 bit)
//
//  A load transaction passes through ST_LOAD and returns to idle. A uniform
//  query runs two divides per axis on the shared divider; a stretched query
//  runs a binary search per axis, whose reads go through the single face
//  memory read port, then at most one shared divide per axis.
//  Reset clears mode, anchors and face counts and sets each size to 65536;
//  the face memory is not cleared. req is not ready while a transaction is
//  in work or its response waits on rsp_ready.
// ----------------------------------------------------------------------------
module grid_point_to_cell_index_core #(
   parameter int unsigned MAX_FACES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   gpci_req_if.sink                       req,
   gpci_rsp_if.source                     rsp,
   input  logic                           csr_write_enable,
   input  logic [gpci_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [gpci_pkg::CoordW-1:0]    csr_write_data
);
   import gpci_pkg::*;

   localparam int unsigned AW = $clog2(MAX_FACES);
   localparam int unsigned CW = $clog2(MAX_FACES + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_AXIS, ST_SRCH_RD, ST_SRCH_CMP, ST_RD_LO, ST_RD_HI,
      ST_FRAC, ST_DIV1, ST_DIV1_WAIT, ST_DIV2_WAIT, ST_NEXT, ST_OUT
   } state_type;

   logic                     mode_ff;
   logic signed [CoordW-1:0] anchor_ff [3];
   logic [SizeW-1:0]         size_ff   [3];
   logic [CW-1:0]            count_ff  [3];

   logic signed [CoordW-1:0] mem [3*MAX_FACES];
   logic signed [CoordW-1:0] rd_ff;
   logic [$clog2(3*MAX_FACES)-1:0] raddr;
   logic                     rd_en;

   state_type                state_ff;
   req_type                  item_ff;
   logic [1:0]               ax_ff;
   logic [CW-1:0]            lo_ff, hi_ff;
   logic signed [CoordW-1:0] flo_ff;
   logic signed [33:0]       res_cell_ff;
   logic signed [49:0]       res_pos_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   div_cmd_type              dcmd;
   div_sts_type              dsts;

   logic signed [CoordW-1:0] pnt;
   logic [CW-1:0]            mid;
   logic [CW-1:0]            isel;
   logic [AW-1:0]            rslot;
   logic signed [CoordW:0]   diff;
   logic signed [CoordW:0]   dlt;
   logic signed [64:0]       qs;
   logic signed [33:0]       cell_sat_src;
   logic signed [CellW-1:0]  cell_sat;
   logic signed [CoordW-1:0] pos_sat;
   logic [SizeW-1:0]         sz;
   logic signed [CoordW:0]   num_s;
   logic                     load_ok;

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   assign load_ok = (item_ff.axis <= AXIS_Z) && (32'(item_ff.face_index) < MAX_FACES);

   assign pnt  = (ax_ff == AXIS_X) ? item_ff.point_x :
                 (ax_ff == AXIS_Y) ? item_ff.point_y : item_ff.point_z;
   assign mid  = CW'((({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1));
   assign isel = (lo_ff < count_ff[ax_ff] - CW'(2)) ? lo_ff : count_ff[ax_ff] - CW'(2);
   assign sz   = (size_ff[ax_ff] == '0) ? SizeW'(1) : size_ff[ax_ff];
   assign diff = (CoordW+1)'(pnt) - (CoordW+1)'(anchor_ff[ax_ff]);
   assign dlt  = (CoordW+1)'(rd_ff) - (CoordW+1)'(flo_ff);
   assign num_s = mode_ff ? ((CoordW+1)'(pnt) - (CoordW+1)'(flo_ff)) : diff;

   // floor quotient from magnitude divide
   assign qs = dcmd.neg ? -$signed({1'b0, dsts.quo}) - 65'(dsts.rem_nz)
                        :  $signed({1'b0, dsts.quo});

   always_comb begin
      rslot = '0;
      rd_en = 1'b0;
      case (state_ff)
         ST_SRCH_RD: begin rslot = AW'(mid);  rd_en = 1'b1; end
         ST_RD_LO:   begin rslot = AW'(isel); rd_en = 1'b1; end
         ST_RD_HI:   begin rslot = AW'(isel + CW'(1)); rd_en = 1'b1; end
         default:    begin rslot = '0; rd_en = 1'b0; end
      endcase
      raddr = $bits(raddr)'(ax_ff) * $bits(raddr)'(MAX_FACES) + $bits(raddr)'(rslot);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD && load_ok)
         mem[$bits(raddr)'(item_ff.axis) * $bits(raddr)'(MAX_FACES)
             + $bits(raddr)'(item_ff.face_index)] <= item_ff.face_value;
      if (rd_en)
         rd_ff <= mem[raddr];
   end

   logic neg_ff;
   logic pass_ff;
   logic [63:0] mag_ff;
   logic [31:0] den_ff;
   assign dcmd.neg   = neg_ff;
   assign dcmd.mag   = mag_ff;
   assign dcmd.den   = den_ff;
   assign dcmd.start = (state_ff == ST_DIV1) || (state_ff == ST_FRAC);

   gpci_divider u_div (.clock(clock), .reset(reset), .cmd(dcmd), .sts(dsts));

   always_comb begin
      cell_sat_src = res_cell_ff;
      cell_sat = (cell_sat_src > 34'sd32767) ? 16'sh7fff :
                 (cell_sat_src < -34'sd32768) ? -16'sh8000 : cell_sat_src[15:0];
      pos_sat  = (res_pos_ff > 50'sh7fffffff) ? 32'sh7fffffff :
                 (res_pos_ff < -50'sh80000000) ? -32'sh80000000 : res_pos_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            anchor_ff[a] <= '0;
            size_ff[a]   <= SizeW'(65536);
            count_ff[a]  <= '0;
         end
         ax_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MODE:     mode_ff      <= csr_write_data[0];
               CSR_ANCHOR_X: anchor_ff[0] <= csr_write_data;
               CSR_ANCHOR_Y: anchor_ff[1] <= csr_write_data;
               CSR_ANCHOR_Z: anchor_ff[2] <= csr_write_data;
               CSR_SIZE_X:   size_ff[0]   <= csr_write_data[SizeW-1:0];
               CSR_SIZE_Y:   size_ff[1]   <= csr_write_data[SizeW-1:0];
               CSR_SIZE_Z:   size_ff[2]   <= csr_write_data[SizeW-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (req.valid && req.ready) begin
               item_ff  <= req.data;
               ax_ff    <= '0;
               state_ff <= (req.data.operation == OP_LOAD) ? ST_LOAD : ST_AXIS;
            end
            ST_LOAD: begin
               if (load_ok && item_ff.last_face)
                  count_ff[item_ff.axis] <= CW'(item_ff.face_index) + CW'(1);
               state_ff <= ST_IDLE;
            end
            ST_AXIS: begin
               lo_ff   <= '0;
               hi_ff   <= count_ff[ax_ff];
               pass_ff <= 1'b0;
               if (mode_ff) state_ff <= ST_SRCH_RD;
               else begin
                  neg_ff   <= diff[CoordW];
                  mag_ff   <= 64'(diff[CoordW] ? -diff : diff);
                  den_ff   <= 32'(sz);
                  state_ff <= ST_DIV1;
               end
            end
            ST_SRCH_RD:
               state_ff <= (hi_ff - lo_ff > CW'(1)) ? ST_SRCH_CMP : ST_RD_LO;
            ST_SRCH_CMP: begin
               if (pnt < rd_ff) hi_ff <= mid; else lo_ff <= mid;
               state_ff <= ST_SRCH_RD;
            end
            ST_RD_LO: begin
               res_cell_ff <= 34'(lo_ff);
               if (count_ff[ax_ff] < CW'(2)) begin
                  res_pos_ff <= '0;
                  state_ff   <= ST_NEXT;
               end else state_ff <= ST_RD_HI;
            end
            ST_RD_HI: begin
               flo_ff   <= rd_ff;
               state_ff <= ST_DIV2_WAIT;
               lo_ff    <= isel;
               hi_ff    <= hi_ff;
            end
            ST_DIV2_WAIT: begin
               // rd_ff now holds face[i+1]
               if (dlt <= 0) begin
                  res_pos_ff <= 50'(lo_ff) <<< 16;
                  state_ff   <= ST_NEXT;
               end else begin
                  neg_ff   <= num_s[CoordW];
                  mag_ff   <= 64'(num_s[CoordW] ? -num_s : num_s) << 16;
                  den_ff   <= dlt[31:0];
                  state_ff <= ST_FRAC;
               end
            end
            ST_FRAC: state_ff <= ST_DIV1_WAIT;
            ST_DIV1: state_ff <= ST_DIV1_WAIT;
            ST_DIV1_WAIT: if (dsts.done) begin
               if (mode_ff) begin
                  res_pos_ff <= (50'(lo_ff) <<< 16) + 50'(qs);
                  state_ff   <= ST_NEXT;
               end else if (!pass_ff) begin
                  // first pass: integer cell; rerun scaled by 2^16
                  res_cell_ff <= 34'(qs);
                  mag_ff      <= mag_ff << 16;
                  pass_ff     <= 1'b1;
                  state_ff    <= ST_DIV1;
               end else begin
                  res_pos_ff <= 50'(qs);
                  state_ff   <= ST_NEXT;
               end
            end
            ST_NEXT: begin
               case (ax_ff)
                  AXIS_X: begin rsp_ff.cell_x <= cell_sat; rsp_ff.pos_x <= pos_sat; end
                  AXIS_Y: begin rsp_ff.cell_y <= cell_sat; rsp_ff.pos_y <= pos_sat; end
                  default: begin rsp_ff.cell_z <= cell_sat; rsp_ff.pos_z <= pos_sat; end
               endcase
               if (ax_ff == AXIS_Z) state_ff <= ST_OUT;
               else begin
                  ax_ff    <= ax_ff + 2'd1;
                  state_ff <= ST_AXIS;
               end
            end
            ST_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |-> !req.ready)
      else $error("accepting while response pending");
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == ST_OUT |=> rsp_valid_ff)
      else $error("response not raised");
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == ST_SRCH_CMP |-> hi_ff > lo_ff)
      else $error("search bounds crossed");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for grid_point_to_cell_index_core. Face loads and point
// queries go in over the req channel with random gaps, and each response is
// compared field by field against an in-bench locator model in both uniform
// and stretched mode. The bench covers directed corner cases, a full-depth
// face table and randomized register phases.
// ----------------------------------------------------------------------------
module tb_top;
   import gpci_pkg::*;

   localparam int     NumFaces   = 1024;
   localparam int     WatchLimit = 6000;
   localparam longint CoordMin   = -64'sd2147483648;
   localparam longint CoordMax   = 64'sd2147483647;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [CsrIdxW-1:0] csr_index;
   logic [CoordW-1:0]  csr_write_data;

   gpci_req_if req_ch();
   gpci_rsp_if rsp_ch();

   grid_point_to_cell_index_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch.sink),
      .rsp              (rsp_ch.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // locator model state
   bit                       cfg_stretched;
   logic signed [CoordW-1:0] cfg_anchor [3];
   logic [SizeW-1:0]         cfg_size [3];
   logic signed [CoordW-1:0] face_pos [3][NumFaces];
   bit                       face_seen [3][NumFaces];
   int unsigned              face_total [3];

   rsp_type expected_locs[$];
   int      error_count;
   int      n_queries, n_loads, n_csr, n_checked;
   bit      req_quiet, rsp_quiet;
   int      idle_cycles;

   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void locate_axis(int a, longint p, output longint cidx,
                                       output longint pidx);
      int unsigned lo, hi, m, k;
      longint span, frac, sz;
      if (cfg_stretched) begin
         lo = 0;
         hi = face_total[a];
         while (hi - lo > 1) begin
            m = (lo + hi) / 2;
            if (p < longint'(face_pos[a][m])) hi = m;
            else lo = m;
         end
         cidx = lo;
         if (face_total[a] < 2) begin
            pidx = 0;
            return;
         end
         k = lo < face_total[a] - 2 ? lo : face_total[a] - 2;
         span = longint'(face_pos[a][k+1]) - longint'(face_pos[a][k]);
         frac = 0;
         if (span > 0) frac = floor_div((p - longint'(face_pos[a][k])) * 65536, span);
         pidx = longint'(k) * 65536 + frac;
      end else begin
         sz = cfg_size[a] == 0 ? 1 : longint'(cfg_size[a]);
         cidx = floor_div(p - longint'(cfg_anchor[a]), sz);
         pidx = floor_div((p - longint'(cfg_anchor[a])) * 65536, sz);
      end
   endfunction

   function automatic rsp_type predict_location(req_type t);
      rsp_type r;
      longint c[3], p[3];
      locate_axis(0, longint'(t.point_x), c[0], p[0]);
      locate_axis(1, longint'(t.point_y), c[1], p[1]);
      locate_axis(2, longint'(t.point_z), c[2], p[2]);
      for (int a = 0; a < 3; a++) begin
         c[a] = clamp(c[a], -32768, 32767);
         p[a] = clamp(p[a], CoordMin, CoordMax);
      end
      r.cell_x = 16'(c[0]);
      r.cell_y = 16'(c[1]);
      r.cell_z = 16'(c[2]);
      r.pos_x  = 32'(p[0]);
      r.pos_y  = 32'(p[1]);
      r.pos_z  = 32'(p[2]);
      return r;
   endfunction

   function automatic void apply_item(req_type t);
      if (t.operation == OP_QUERY) begin
         expected_locs = {expected_locs, predict_location(t)};
         n_queries++;
      end else begin
         n_loads++;
         if (t.axis <= AXIS_Z) begin
            face_pos[t.axis][t.face_index]  = t.face_value;
            face_seen[t.axis][t.face_index] = 1'b1;
            if (t.last_face) face_total[t.axis] = int'(t.face_index) + 1;
         end
      end
   endfunction

   task automatic send_item(req_type t);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= t;
      do @(posedge clock); while (!req_ch.ready);
      apply_item(t);
   endtask

   task automatic load_face(int a, int idx, logic signed [CoordW-1:0] v, bit last);
      req_type t;
      t = '0;
      t.operation  = OP_LOAD;
      t.axis       = a[AxisW-1:0];
      t.face_index = idx[SlotW-1:0];
      t.face_value = v;
      t.last_face  = last;
      t.point_x    = $urandom;
      t.point_y    = $urandom;
      t.point_z    = $urandom;
      send_item(t);
   endtask

   task automatic send_query(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                             logic signed [CoordW-1:0] z);
      req_type t;
      t.operation  = OP_QUERY;
      t.axis       = AxisW'($urandom);
      t.face_index = SlotW'($urandom);
      t.face_value = $urandom;
      t.last_face  = 1'($urandom);
      t.point_x    = x;
      t.point_y    = y;
      t.point_z    = z;
      send_item(t);
   endtask

   // lowers valid in the step of the last transaction, then lets the core settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_locs.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [CoordW-1:0] v);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= v;
      @(posedge clock);
      n_csr++;
      case (idx)
         CSR_MODE:     cfg_stretched = v[0];
         CSR_ANCHOR_X: cfg_anchor[0] = v;
         CSR_ANCHOR_Y: cfg_anchor[1] = v;
         CSR_ANCHOR_Z: cfg_anchor[2] = v;
         CSR_SIZE_X:   cfg_size[0]   = v[SizeW-1:0];
         CSR_SIZE_Y:   cfg_size[1]   = v[SizeW-1:0];
         CSR_SIZE_Z:   cfg_size[2]   = v[SizeW-1:0];
         default: ;
      endcase
   endtask

   task automatic end_regs();
      csr_write_enable <= 1'b0;
   endtask

   task automatic fill_axis(int a, int n, bit ordered);
      longint step_max, v;
      int     r;
      step_max = 64'sd4294967296 / (n + 1);
      r = $urandom_range(0, 2);
      if (r == 1 && step_max > 256) step_max = 256;
      if (r == 2 && step_max > 1048576) step_max = 1048576;
      v = CoordMin + longint'($urandom_range(0, 32'(step_max - 1)));
      for (int k = 0; k < n; k++) begin
         load_face(a, k, ordered ? 32'(v) : 32'($urandom), k == n - 1);
         v += longint'($urandom_range(r == 1 ? 0 : 1, 32'(step_max)));
      end
   endtask

   function automatic logic signed [CoordW-1:0] pick_coord(int a);
      int     r, k, m;
      longint lo, hi, v, sz;
      r = $urandom_range(0, 9);
      if (r < 6 && cfg_stretched && face_total[a] >= 2) begin
         k  = $urandom_range(0, face_total[a] - 2);
         lo = face_pos[a][k];
         hi = face_pos[a][k+1];
         if (r == 0 || hi <= lo) return 32'(lo);
         return 32'(lo + longint'($urandom_range(0, 32'(hi - lo - 1))));
      end
      if (r < 6 && !cfg_stretched) begin
         sz = cfg_size[a] == 0 ? 1 : longint'(cfg_size[a]);
         m  = $urandom_range(0, 40);
         v  = longint'(cfg_anchor[a]) + longint'(m - 20) * sz
              + longint'($urandom_range(0, 32'(sz - 1)));
         return 32'(clamp(v, CoordMin, CoordMax));
      end
      if (r < 8) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   task automatic random_query();
      send_query(pick_coord(0), pick_coord(1), pick_coord(2));
   endtask

   task automatic noise_load();
      int a, idx;
      bit last;
      a    = $urandom_range(0, 3);
      idx  = $urandom_range(0, NumFaces - 1);
      last = $urandom_range(0, 1);
      if (last && a <= 2)
         for (int k = 0; k < idx; k++) if (!face_seen[a][k]) last = 1'b0;
      load_face(a, idx, $urandom, last);
   endtask

   function automatic logic [CoordW-1:0] pick_anchor();
      case ($urandom_range(0, 4))
         0: return 32'h0;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CoordW-1:0] pick_size();
      case ($urandom_range(0, 6))
         0: return 32'h0;
         1: return 32'h1;
         2: return 32'h7FFF_FFFF;
         3: return 32'h0001_0000;
         4: return $urandom_range(1, 4096);
         5: return $urandom_range(1 << 14, 1 << 20);
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_uniform_directed();
      send_query(32'h0, 32'h0, 32'h0);
      send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_query(32'h0003_0005, 32'hFFFD_FFFF, 32'h0000_0001);
      drain();
      write_reg(CSR_ANCHOR_X, 32'h8000_0000);
      write_reg(CSR_ANCHOR_Y, 32'h7FFF_FFFF);
      write_reg(CSR_ANCHOR_Z, 32'h0001_8000);
      write_reg(CSR_SIZE_X, 32'h1);
      write_reg(CSR_SIZE_Y, 32'h0);
      write_reg(CSR_SIZE_Z, 32'h7FFF_FFFF);
      end_regs();
      send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_query(32'h8000_0005, 32'h7FFF_FFF0, 32'h8000_0000);
      drain();
   endtask

   task automatic test_stretched_special();
      write_reg(CSR_MODE, 32'h1);
      end_regs();
      send_query(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      load_face(3, 5, 32'h1234_5678, 1'b1);
      load_face(0, 0, 32'h0000_1000, 1'b1);
      send_query(32'h0000_0000, 32'h0000_1000, 32'h7FFF_FFFF);
      load_face(1, 0, -32'sd100, 1'b0);
      load_face(1, 1, -32'sd100, 1'b0);
      load_face(1, 2, -32'sd200, 1'b0);
      load_face(1, 3, 32'sd1000, 1'b1);
      load_face(2, 0, 32'h8000_0000, 1'b0);
      load_face(2, 1, 32'h7FFF_FFFF, 1'b1);
      send_query(32'h0, -32'sd100, 32'h8000_0000);
      send_query(32'h0, -32'sd150, 32'h7FFF_FFFF);
      send_query(32'h0, 32'sd500, 32'h0);
      send_query(32'h0, 32'h8000_0000, 32'hFFFF_FFFF);
      send_query(32'h0, 32'h7FFF_FFFF, 32'h0000_0001);
      drain();
   endtask

   task automatic test_full_table();
      fill_axis(0, NumFaces, 1'b1);
      fill_axis(1, $urandom_range(2, 16), 1'b1);
      fill_axis(2, $urandom_range(2, 16), 1'b0);
      repeat (30) random_query();
      drain();
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_reg(CSR_MODE, (ph % 3 == 0) ? 32'h0 : 32'h1);
         write_reg(CSR_ANCHOR_X, pick_anchor());
         write_reg(CSR_ANCHOR_Y, pick_anchor());
         write_reg(CSR_ANCHOR_Z, pick_anchor());
         write_reg(CSR_SIZE_X, pick_size());
         write_reg(CSR_SIZE_Y, pick_size());
         write_reg(CSR_SIZE_Z, pick_size());
         end_regs();
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         for (int a = 0; a < 3; a++)
            if ($urandom_range(0, 2) != 0)
               fill_axis(a, $urandom_range(0, 7) == 0 ? $urandom_range(1, 2)
                                                      : $urandom_range(2, 40),
                         $urandom_range(0, 5) != 0);
         repeat (40) begin
            if ($urandom_range(0, 99) < 15) noise_load();
            else random_query();
         end
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   // ---------------------------------------------------------------- checker
   initial begin
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         int gap;
         rsp_type got, want;
         gap = rsp_quiet ? 0 : $urandom_range(0, 18);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got = rsp_ch.data;
         if (expected_locs.size() == 0) begin
            $error("unexpected response transaction");
            error_count++;
         end else begin
            want = expected_locs.pop_front();
            n_checked++;
            if (got.cell_x !== want.cell_x) begin
               $error("cell_x expected %0d got %0d", want.cell_x, got.cell_x); error_count++;
            end
            if (got.cell_y !== want.cell_y) begin
               $error("cell_y expected %0d got %0d", want.cell_y, got.cell_y); error_count++;
            end
            if (got.cell_z !== want.cell_z) begin
               $error("cell_z expected %0d got %0d", want.cell_z, got.cell_z); error_count++;
            end
            if (got.pos_x !== want.pos_x) begin
               $error("pos_x expected %0d got %0d", want.pos_x, got.pos_x); error_count++;
            end
            if (got.pos_y !== want.pos_y) begin
               $error("pos_y expected %0d got %0d", want.pos_y, got.pos_y); error_count++;
            end
            if (got.pos_z !== want.pos_z) begin
               $error("pos_z expected %0d got %0d", want.pos_z, got.pos_z); error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_write_enable) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchLimit) begin
            $display("grid_point_to_cell_index_core verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- main
   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data      <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      cfg_stretched    = 1'b0;
      for (int a = 0; a < 3; a++) begin
         cfg_anchor[a] = '0;
         cfg_size[a]   = 31'd65536;
         face_total[a] = 0;
         for (int k = 0; k < NumFaces; k++) face_seen[a][k] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_uniform_directed();
      test_stretched_special();
      test_full_table();
      test_random_phases();

      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d queries, %0d face loads, %0d register writes",
               n_queries, n_loads, n_csr);
      $display("%0d responses compared, %0d mismatches", n_checked, error_count);
      if (error_count == 0)
         $display("grid_point_to_cell_index_core verification clean");
      else
         $display("grid_point_to_cell_index_core verification failed");
      $finish;
   end

endmodule
